>>> design/psc_pkg.sv
// Shared types and constants for the pairwise separation check.
// Depends on nothing; imported by the store, the arithmetic unit and the top level.
`default_nettype none

package psc_pkg;

   // Field widths fixed by the interface
   localparam int ID_W   = 16;
   localparam int POS_W  = 24;
   localparam int DIFF_W = POS_W + 1;     // magnitude of a position difference
   localparam int SQ_W   = 2 * DIFF_W;    // square and sum of two squares
   localparam int HMIN_W = 23;
   localparam int VMIN_W = 24;
   localparam int CSR_W  = 24;

   // Register indexes on the csr channel
   localparam logic REG_HMIN = 1'b0;
   localparam logic REG_VMIN = 1'b1;

   // Result kinds
   localparam logic KIND_ALERT = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   // Axis select for the shared difference unit
   localparam int SEL_W = 2;
   localparam logic [SEL_W-1:0] SEL_X = 2'd0;
   localparam logic [SEL_W-1:0] SEL_Y = 2'd1;
   localparam logic [SEL_W-1:0] SEL_Z = 2'd2;

   // One stored target report
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
   } psc_entry_type;

   // Per-cycle command from the sequencer to the arithmetic unit
   typedef struct packed {
      logic [SEL_W-1:0] sel;       // axis fed to the difference stage
      logic             diff_en;   // load |a - b| of the selected axis
      logic             zok_en;    // latch the vertical compare
      logic             sq_en;     // load the square of the difference
      logic             acc_en;    // move the first square to the accumulator
      logic             mul_hmin;  // square the horizontal minimum instead
   } psc_op_type;

endpackage : psc_pkg

`default_nettype wire

>>> design/psc_store.sv
// Report store: one write port, two registered read ports.
// Depends on psc_pkg for the entry type.
`default_nettype none

module psc_store import psc_pkg::*; #(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire psc_entry_type    wr_data,
   input  wire logic [IDX_W-1:0] rd_a_addr,
   input  wire logic [IDX_W-1:0] rd_b_addr,
   output      psc_entry_type    rd_a_data,
   output      psc_entry_type    rd_b_data
);

   psc_entry_type store_ff [DEPTH];
   psc_entry_type rd_a_ff;
   psc_entry_type rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // two read ports, data registered
   always_ff @(posedge clock) begin
      rd_a_ff <= store_ff[rd_a_addr];
      rd_b_ff <= store_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule : psc_store

`default_nettype wire

>>> design/psc_unit.sv
// Shared arithmetic unit: absolute difference, one squarer and the
// separation compare, stepped by the sequencer. Depends on psc_pkg.
`default_nettype none

module psc_unit import psc_pkg::*; (
   input  wire logic              clock,
   input  wire psc_op_type        op,
   input  wire psc_entry_type     ent_a,
   input  wire psc_entry_type     ent_b,
   input  wire logic [HMIN_W-1:0] hmin,
   input  wire logic [VMIN_W-1:0] vmin,
   output      logic              hit
);

   logic [POS_W-1:0]        opa;
   logic [POS_W-1:0]        opb;
   logic signed [DIFF_W-1:0] delta;
   logic [DIFF_W-1:0]       mag;
   logic [DIFF_W-1:0]       mul_src;
   logic [SQ_W-1:0]         prod;
   logic [SQ_W-1:0]         dist2;

   logic [DIFF_W-1:0] diff_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [SQ_W-1:0]   acc_ff;
   logic [SQ_W-1:0]   hmin2_ff;
   logic              zok_ff;

   // axis select
   always_comb begin
      unique case (op.sel)
         SEL_X:   begin opa = ent_a.x; opb = ent_b.x; end
         SEL_Y:   begin opa = ent_a.y; opb = ent_b.y; end
         SEL_Z:   begin opa = ent_a.z; opb = ent_b.z; end
         default: begin opa = ent_a.z; opb = ent_b.z; end
      endcase
   end

   // |a - b| on sign-extended positions, never overflows 25 bits
   assign delta = $signed({opa[POS_W-1], opa}) - $signed({opb[POS_W-1], opb});
   assign mag   = delta[DIFF_W-1] ? DIFF_W'(-delta) : DIFF_W'(delta);

   // the one squarer
   assign mul_src = op.mul_hmin ? {{(DIFF_W-HMIN_W){1'b0}}, hmin} : diff_ff;
   assign prod    = SQ_W'(mul_src) * SQ_W'(mul_src);

   always_ff @(posedge clock) begin
      if (op.diff_en) begin
         diff_ff <= mag;
      end
      if (op.zok_en) begin
         zok_ff <= diff_ff < {1'b0, vmin};
      end
      if (op.sq_en) begin
         sq_ff <= prod;
      end
      if (op.acc_en) begin
         acc_ff <= sq_ff;
      end
      if (op.mul_hmin) begin
         hmin2_ff <= prod;
      end
   end

   // each square is below 2^49, so the sum fits
   assign dist2 = acc_ff + sq_ff;
   assign hit   = (dist2 < hmin2_ff) && zok_ff;

endmodule : psc_unit

`default_nettype wire

>>> design/pairwise_separation_check.sv
// Pairwise separation check: stores target reports, then on the scan's last report
// walks every pair (i < j) through one shared difference/square unit.
// Reports without scan_last are accepted back to back while idle. A closing report starts
// the pair walk: the horizontal minimum is squared, then each of the n * (n - 1) / 2 pairs
// takes six sequencer steps, and a held result stalls an alert or the done result.
// Reset (synchronous, active high) empties the store count and restores register defaults.
`default_nettype none

module pairwise_separation_check import psc_pkg::*; #(
   parameter int MAX_TARGETS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // report input
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [ID_W-1:0]   req_target_id,
   input  wire logic signed [POS_W-1:0] req_pos_x,
   input  wire logic signed [POS_W-1:0] req_pos_y,
   input  wire logic signed [POS_W-1:0] req_pos_z,
   input  wire logic              req_scan_last,
   // results
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic              rsp_kind,
   output      logic [ID_W-1:0]   rsp_first_id,
   output      logic [ID_W-1:0]   rsp_second_id,
   output      logic              rsp_overflow,
   output      logic              rsp_last,
   // register writes
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic              csr_index,
   input  wire logic [CSR_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(MAX_TARGETS);
   localparam int CNT_W = $clog2(MAX_TARGETS + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_TARGETS);

   // sequencer states
   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE = 4'd0;
   localparam logic [STATE_W-1:0] S_HMIN = 4'd1;
   localparam logic [STATE_W-1:0] S_RD   = 4'd2;
   localparam logic [STATE_W-1:0] S_DZ   = 4'd3;
   localparam logic [STATE_W-1:0] S_DX   = 4'd4;
   localparam logic [STATE_W-1:0] S_SQX  = 4'd5;
   localparam logic [STATE_W-1:0] S_SQY  = 4'd6;
   localparam logic [STATE_W-1:0] S_CMP  = 4'd7;
   localparam logic [STATE_W-1:0] S_DONE = 4'd8;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [HMIN_W-1:0]  hmin_ff, hmin_in;
   logic [VMIN_W-1:0]  vmin_ff, vmin_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [ID_W-1:0]    rsp_second_ff, rsp_second_in;
   logic               rsp_overflow_ff, rsp_overflow_in;
   logic               rsp_last_ff, rsp_last_in;

   psc_op_type    op;
   psc_entry_type wr_entry;
   psc_entry_type ent_a;
   psc_entry_type ent_b;
   logic          store_wr;
   logic          unit_hit;
   logic          out_free;
   logic          load_alert;
   logic          load_done;
   logic          j_last;
   logic          i_last;
   logic [IDX_W-1:0] i_nxt;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // store
   assign store_wr = req_valid && req_ready && (count_ff < CAP);
   assign wr_entry = '{id: req_target_id, x: req_pos_x, y: req_pos_y, z: req_pos_z};

   psc_store #(
      .DEPTH (MAX_TARGETS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (store_wr),
      .wr_addr   (count_ff[IDX_W-1:0]),
      .wr_data   (wr_entry),
      .rd_a_addr (i_ff),
      .rd_b_addr (j_ff),
      .rd_a_data (ent_a),
      .rd_b_data (ent_b)
   );

   psc_unit u_unit (
      .clock (clock),
      .op    (op),
      .ent_a (ent_a),
      .ent_b (ent_b),
      .hmin  (hmin_ff),
      .vmin  (vmin_ff),
      .hit   (unit_hit)
   );

   // pair walk position
   assign i_nxt  = i_ff + IDX_W'(1);
   assign j_last = (CNT_W'(j_ff) + CNT_W'(1)) == count_ff;
   assign i_last = (CNT_W'(i_ff) + CNT_W'(2)) == count_ff;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      op         = '0;
      op.sel     = SEL_Z;
      load_alert = 1'b0;
      load_done  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (count_ff < CAP) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_scan_last) begin
                  state_in = S_HMIN;
                  i_in     = '0;
                  j_in     = IDX_W'(1);
               end
            end
         end
         S_HMIN: begin
            op.mul_hmin = 1'b1;
            state_in    = (count_ff < CNT_W'(2)) ? S_DONE : S_RD;
         end
         S_RD: begin
            state_in = S_DZ;
         end
         S_DZ: begin
            op.sel     = SEL_Z;
            op.diff_en = 1'b1;
            state_in   = S_DX;
         end
         S_DX: begin
            op.zok_en  = 1'b1;
            op.sel     = SEL_X;
            op.diff_en = 1'b1;
            state_in   = S_SQX;
         end
         S_SQX: begin
            op.sq_en   = 1'b1;
            op.sel     = SEL_Y;
            op.diff_en = 1'b1;
            state_in   = S_SQY;
         end
         S_SQY: begin
            op.sq_en  = 1'b1;
            op.acc_en = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            // an alert waits here for the output register
            if (!unit_hit || out_free) begin
               load_alert = unit_hit;
               if (j_last && i_last) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD;
                  if (j_last) begin
                     i_in = i_nxt;
                     j_in = i_nxt + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               load_done  = 1'b1;
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // register writes
   always_comb begin
      hmin_in = hmin_ff;
      vmin_in = vmin_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HMIN: hmin_in = csr_data[HMIN_W-1:0];
            REG_VMIN: vmin_in = csr_data[VMIN_W-1:0];
            default:  hmin_in = hmin_ff;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_second_in   = rsp_second_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_last_in     = rsp_last_ff;
      if (load_alert) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = KIND_ALERT;
         rsp_first_in    = ent_a.id;
         rsp_second_in   = ent_b.id;
         rsp_overflow_in = 1'b0;
         rsp_last_in     = 1'b0;
      end else if (load_done) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = KIND_DONE;
         rsp_first_in    = '0;
         rsp_second_in   = '0;
         rsp_overflow_in = dropped_ff;
         rsp_last_in     = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         hmin_ff      <= HMIN_W'(3000);
         vmin_ff      <= VMIN_W'(1000);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         hmin_ff      <= hmin_in;
         vmin_ff      <= vmin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_kind_ff     <= rsp_kind_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_second_ff   <= rsp_second_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_first_id  = rsp_first_ff;
   assign rsp_second_id = rsp_second_ff;
   assign rsp_overflow  = rsp_overflow_ff;
   assign rsp_last      = rsp_last_ff;

   // a pair being read is always ordered and inside the store
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |->
         ((CNT_W'(i_ff) < CNT_W'(j_ff)) && (CNT_W'(j_ff) < count_ff)))
      else $error("pair index out of order or beyond stored count");

   // loading the done result leaves the block idle and empty
   a_done_clears : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && out_free) |=>
         ((state_ff == S_IDLE) && (count_ff == '0) && !dropped_ff
          && rsp_valid_ff && rsp_last_ff))
      else $error("scan state not cleared when done result loaded");

   // a flagged pair becomes an alert in the output register
   a_alert_loaded : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CMP) && unit_hit && out_free) |=>
         (rsp_valid_ff && (rsp_kind_ff == KIND_ALERT) && !rsp_last_ff))
      else $error("flagged pair not presented as alert");

endmodule : pairwise_separation_check

`default_nettype wire
